@@ rtl/gbs_pkg.sv @@
// Package for the greedy box suppression block: word types, stored box layout,
// sequencer states and fixed constants. No dependencies.
package gbs_pkg;

  // One input word: a detection box in 1/16 pixel units.
  typedef struct packed {
    logic               first_of_frame;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]        box_w;
    logic [14:0]        box_h;
  } gbs_in_t;

  // One result word.
  typedef struct packed {
    logic        keep;
    logic [15:0] box_index;
    logic        store_full;
  } gbs_out_t;

  // A box as it lives in the kept-box memory.
  typedef struct packed {
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]        box_w;
    logic [14:0]        box_h;
  } gbs_box_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } gbs_state_t;

  localparam logic [15:0] THR_RESET = 16'd29491;
  localparam logic [15:0] INDEX_MAX = 16'hFFFF;

endpackage

@@ rtl/gbs_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module gbs_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/greedy_box_suppression_top.sv @@
// Top level of the greedy IoU box suppression block: sequencer, overlap pipeline
// and result register. Depends on gbs_pkg and gbs_ram.

// Usage
// Boxes arrive one word at a time on the in_ channel, highest score first. A word
// with first_of_frame set empties the kept-box store and restarts the box index.
// Every input word yields exactly one result word on the out_ channel: keep, the
// box index within the frame, and store_full when a surviving box found no room.
// The block handles one box at a time and takes input only while idle. After a box
// is accepted, the sequencer streams every kept box of the frame out of the memory,
// one read per cycle, into a five-stage overlap pipeline. When the scan ends, the
// sequencer waits for the pipeline to drain and then loads the result; with no box
// kept yet, it skips the scan and loads the result directly. The next box can be
// accepted once the result is loaded, so the time per box grows with the number
// of kept boxes, which the memory read port streams one entry at a time.
// The result sits in an output register, so the next box is accepted while the
// previous result waits. If the receiver stalls, the finished decision of the
// following box is held back until the waiting result has been taken.
// cfg_we writes the IoU threshold (a 0.16 fraction); write it only while idle.
// Reset (synchronous, active low) empties the store, zeroes the index and loads
// the default threshold. It needs no clearing pass: only written entries are read.
module greedy_box_suppression_top
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  gbs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output gbs_out_t out_data,
  input  logic     cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int KW = $clog2(MAX_KEPT > 1 ? MAX_KEPT : 2);
  localparam int CW = KW + 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_KEPT);

  gbs_state_t state_r, state_nxt;

  logic [15:0]   thr_r;
  logic [CW-1:0] kept_cnt_r, kept_cnt_nxt;
  logic [15:0]   frame_cnt_r, frame_cnt_nxt;
  logic [KW-1:0] scan_r, scan_nxt;

  // Box under test and its bookkeeping.
  gbs_box_t      box_r;
  logic [29:0]   area_r;
  logic [15:0]   idx_r;
  logic          hit_r;

  logic          accept;
  logic          rd_en;
  logic          wr_en;
  logic          decide_fire;
  logic          scan_last;
  logic          pipe_busy;
  logic [15:0]   idx_eff;
  logic [CW-1:0] cnt_eff;

  logic [$bits(gbs_box_t)-1:0] rd_word;
  gbs_box_t kbox;

  // Overlap pipeline.
  logic          v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [14:0]   ox_r, oy_r, kw_r, kh_r;
  logic [29:0]   inter3_r, karea_r;
  logic [29:0]   inter4_r, inter5_r;
  logic [30:0]   uni_r;
  logic [46:0]   prod_r;
  logic [14:0]   ox_nxt, oy_nxt;
  logic          cmp_hit;

  gbs_out_t      out_r;
  logic          out_valid_r;

  assign accept  = in_valid && !in_stall;
  assign idx_eff = in_data.first_of_frame ? 16'd0 : frame_cnt_r;
  assign cnt_eff = in_data.first_of_frame ? '0 : kept_cnt_r;
  assign scan_last = (CW'({1'b0, scan_r}) + CW'(1)) == kept_cnt_r;
  assign pipe_busy = v1_r || v2_r || v3_r || v4_r || v5_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (cnt_eff == '0) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (decide_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs. The memory is written only in DECIDE, after the pipeline
  // has drained, so a read never overlaps a write to the same entry.
  always_comb begin
    in_stall    = 1'b1;
    rd_en       = 1'b0;
    decide_fire = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_SCAN:   rd_en = 1'b1;
      ST_DRAIN:  ;
      ST_DECIDE: decide_fire = !(out_valid_r && out_stall);
      default:   ;
    endcase
    wr_en = decide_fire && !hit_r && (kept_cnt_r < MAX_CNT);
  end

  always_comb begin
    kept_cnt_nxt  = kept_cnt_r;
    frame_cnt_nxt = frame_cnt_r;
    scan_nxt      = scan_r;
    if (accept) begin
      kept_cnt_nxt  = cnt_eff;
      frame_cnt_nxt = (idx_eff == INDEX_MAX) ? INDEX_MAX : idx_eff + 16'd1;
      scan_nxt      = '0;
    end else if (rd_en) begin
      scan_nxt = scan_r + KW'(1);
    end else if (wr_en) begin
      kept_cnt_nxt = kept_cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THR_RESET;
      kept_cnt_r  <= '0;
      frame_cnt_r <= '0;
      scan_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kept_cnt_r  <= kept_cnt_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      scan_r      <= scan_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (accept) begin
        hit_r <= 1'b0;
      end else if (v5_r && cmp_hit) begin
        hit_r <= 1'b1;
      end
      if (decide_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      v1_r <= rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Latch the box under test together with its own area.
  always_ff @(posedge clk) begin
    if (accept) begin
      box_r.box_x <= in_data.box_x;
      box_r.box_y <= in_data.box_y;
      box_r.box_w <= in_data.box_w;
      box_r.box_h <= in_data.box_h;
      area_r      <= 30'(in_data.box_w) * 30'(in_data.box_h);
      idx_r       <= idx_eff;
    end
  end

  gbs_ram #(
    .WIDTH ($bits(gbs_box_t)),
    .DEPTH (MAX_KEPT),
    .AW    (KW)
  ) u_kept_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (kept_cnt_r[KW-1:0]),
    .wdata (box_r),
    .re    (rd_en),
    .raddr (scan_r),
    .rdata (rd_word)
  );

  assign kbox = gbs_box_t'(rd_word);

  // Overlap length along one axis, zero when the spans only touch or are apart.
  // The overlap never exceeds either length, so 15 bits hold it.
  function automatic logic [14:0] span_overlap(
    input logic signed [15:0] a0, input logic [14:0] al,
    input logic signed [15:0] b0, input logic [14:0] bl
  );
    logic signed [17:0] as, ae, bs, be, lo, hi, d;
    as = 18'(a0);
    bs = 18'(b0);
    ae = as + $signed({3'b000, al});
    be = bs + $signed({3'b000, bl});
    lo = (as > bs) ? as : bs;
    hi = (ae < be) ? ae : be;
    d  = hi - lo;
    return (d > 18'sd0) ? d[14:0] : 15'd0;
  endfunction

  assign ox_nxt = span_overlap(box_r.box_x, box_r.box_w, kbox.box_x, kbox.box_w);
  assign oy_nxt = span_overlap(box_r.box_y, box_r.box_h, kbox.box_y, kbox.box_h);

  // Stage 2: overlap lengths. Stage 3: intersection and kept area. Stage 4: union.
  // Stage 5: threshold times union. The compare against inter << 16 closes the loop.
  always_ff @(posedge clk) begin
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    kw_r     <= kbox.box_w;
    kh_r     <= kbox.box_h;
    inter3_r <= 30'(ox_r) * 30'(oy_r);
    karea_r  <= 30'(kw_r) * 30'(kh_r);
    uni_r    <= 31'(area_r) + 31'(karea_r) - 31'(inter3_r);
    inter4_r <= inter3_r;
    prod_r   <= 47'(thr_r) * 47'(uni_r);
    inter5_r <= inter4_r;
  end

  assign cmp_hit = {1'b0, inter5_r, 16'd0} > prod_r;

  always_ff @(posedge clk) begin
    if (decide_fire) begin
      out_r.keep       <= wr_en;
      out_r.box_index  <= idx_r;
      out_r.store_full <= !hit_r && (kept_cnt_r == MAX_CNT);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_cnt_r <= MAX_CNT)
    else $error("kept count exceeds store depth");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("kept store written during a scan");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pipe_busy)
    else $error("overlap pipeline busy while idle");

  a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DECIDE))
    else $error("result loaded outside the decision step");
`endif

endmodule
